// ----- rtl/core/gso_pkg.sv -----
// Shared constants, widths and tables for the gated sine oscillator.
// Used by gso_cordic, gso_scale and gated_sine_oscillator_unit.
// No dependencies.
package gso_pkg;

   // Block sizing
   localparam int MAX_FRAMES   = 64;
   localparam int PHASE_BITS   = 32;
   localparam int SAMPLE_BITS  = 16;
   localparam int CORDIC_STEPS = 16;

   // Field and register widths
   localparam int COUNT_W     = 7;
   localparam int FRAMES_W    = $clog2(MAX_FRAMES + 1);
   localparam int STEP_W      = 32;
   localparam int AMP_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTE_ENABLE = 2'd2;

   // Register reset values
   localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd39370534;
   localparam logic [AMP_W-1:0]  AMP_UNITY        = 16'd32768;

   // CORDIC datapath: 32-bit binary angle, Q30 vector
   localparam int ANGLE_W  = 32;
   localparam int CORDIC_W = 34;
   localparam int ITER_W   = $clog2(CORDIC_STEPS);
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;

   // Scaling: Q30 sine times Q15 gain, back to Q(SAMPLE_BITS-1)
   localparam int PROD_W    = CORDIC_W + AMP_W + 1;
   localparam int OUT_SHIFT = 46 - SAMPLE_BITS;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (OUT_SHIFT - 1));
   localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [PROD_W-1:0] SAT_LO     = -PROD_W'(64'sd1 <<< (SAMPLE_BITS - 1));

   // Phase to 32-bit angle alignment
   localparam int PH_DOWN = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int PH_UP   = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;

   function automatic logic [ANGLE_W-1:0] phase_to_angle(input logic [PHASE_BITS-1:0] ph);
      logic [63:0] wide;
      wide = (64'(ph) >> PH_DOWN) << PH_UP;
      return wide[ANGLE_W-1:0];
   endfunction

   // Arctangent of 2^-i as a fraction of one turn, 2^32 = full cycle
   function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
      logic [ANGLE_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/gated_sine_oscillator_unit.sv -----
// Top level of the gated sine oscillator: registers, sample sequencer,
// phase accumulator and output register. Uses gso_cordic and gso_scale.
// Depends on gso_pkg.
//
//   Channel  Ports                                  Direction  Moves
//   req      req_valid/req_ready, req_frame_count   in         one block request
//   rsp      rsp_valid/rsp_ready, rsp_sample/last   out        one sample
//   csr      csr_we, csr_index, csr_wdata           in         register write
//
// Each sample passes through a phase step, a CORDIC load, the micro-rotations
// on the shared shift-add unit, the registered product and sample of the gain
// stage and the output register, where it waits until rsp_ready takes it.
// A request of N frames holds req_ready low until its last sample is taken; a
// request with the gate closed or a zero count is accepted and makes no sample.
// Reset clears the phase and loads the register defaults.
module gated_sine_oscillator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [gso_pkg::COUNT_W-1:0]            req_frame_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [gso_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                   rsp_last,
   input  logic                                   csr_we,
   input  logic [gso_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [gso_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import gso_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_STEP   = 3'd1;
   localparam logic [2:0] ST_ROTATE = 3'd2;
   localparam logic [2:0] ST_SCALE  = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [STEP_W-1:0]             phase_step_ff, phase_step_in;
   logic [AMP_W-1:0]              amplitude_ff, amplitude_in;
   logic                          note_enable_ff, note_enable_in;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic [FRAMES_W-1:0]           frames_left_ff, frames_left_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_fire, rsp_fire;
   logic [PHASE_BITS-1:0]         phase_sum;
   logic [FRAMES_W-1:0]           frames_req;
   logic [AMP_W-1:0]              gain;
   logic                          cordic_start, cordic_done;
   logic signed [CORDIC_W-1:0]    cordic_sine;
   logic                          scale_done;
   logic signed [SAMPLE_BITS-1:0] scale_sample;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid_ff & rsp_ready;

   // Clamp the request to the block limit and the gain to unity
   assign frames_req = (req_frame_count > COUNT_W'(MAX_FRAMES)) ?
                       FRAMES_W'(MAX_FRAMES) : FRAMES_W'(req_frame_count);
   assign gain       = (amplitude_ff > AMP_UNITY) ? AMP_UNITY : amplitude_ff;

   // Advance the phase with modulo wrap
   assign phase_sum    = phase_ff + PHASE_BITS'(phase_step_ff);
   assign cordic_start = (state_ff == ST_STEP);

   // Register writes
   always_comb begin
      phase_step_in  = phase_step_ff;
      amplitude_in   = amplitude_ff;
      note_enable_in = note_enable_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:  phase_step_in  = csr_wdata[STEP_W-1:0];
            CSR_AMPLITUDE:   amplitude_in   = csr_wdata[AMP_W-1:0];
            CSR_NOTE_ENABLE: note_enable_in = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // Sample sequencer
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      frames_left_in = frames_left_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && note_enable_ff && (frames_req != '0)) begin
               frames_left_in = frames_req;
               state_in       = ST_STEP;
            end
         end
         ST_STEP: begin
            phase_in = phase_sum;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (cordic_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (scale_done) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = scale_sample;
               rsp_last_in   = (frames_left_ff == FRAMES_W'(1));
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               rsp_valid_in   = 1'b0;
               frames_left_in = frames_left_ff - 1'b1;
               state_in       = rsp_last_ff ? ST_IDLE : ST_STEP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_step_ff  <= PHASE_STEP_RESET;
         amplitude_ff   <= AMP_UNITY;
         note_enable_ff <= 1'b0;
         phase_ff       <= '0;
         frames_left_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_step_ff  <= phase_step_in;
         amplitude_ff   <= amplitude_in;
         note_enable_ff <= note_enable_in;
         phase_ff       <= phase_in;
         frames_left_ff <= frames_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold the output payload
   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   gso_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (phase_to_angle(phase_sum)),
      .done  (cordic_done),
      .sine  (cordic_sine)
   );

   gso_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_done),
      .sine   (cordic_sine),
      .gain   (gain),
      .done   (scale_done),
      .sample (scale_sample)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ----- rtl/core/gso_cordic.sv -----
// Iterative rotation-mode CORDIC: one shift-add micro-rotation per cycle.
// Produces the Q30 sine of a 32-bit binary angle.
// Depends on gso_pkg.
module gso_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [gso_pkg::ANGLE_W-1:0]           angle,
   output logic                                  done,
   output logic signed [gso_pkg::CORDIC_W-1:0]   sine
);
   import gso_pkg::*;

   logic                       running_ff, running_in;
   logic                       done_ff, done_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;

   logic [1:0]                 quadrant;
   logic [ANGLE_W-1:0]         folded;
   logic signed [CORDIC_W-1:0] x_shift, y_shift, atan_val;
   logic                       rotate_pos;
   logic                       last_iter;

   // Fold second and third quadrants onto the first and fourth
   assign quadrant = angle[ANGLE_W-1 -: 2];
   assign folded   = (quadrant == 2'd1 || quadrant == 2'd2) ?
                     (32'h8000_0000 - angle) : angle;

   // Shared shifter and adders for one micro-rotation
   assign x_shift    = x_ff >>> iter_ff;
   assign y_shift    = y_ff >>> iter_ff;
   assign atan_val   = CORDIC_W'(atan_turn(5'(iter_ff)));
   assign rotate_pos = ~z_ff[CORDIC_W-1];
   assign last_iter  = (iter_ff == ITER_W'(CORDIC_STEPS - 1));

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      if (start) begin
         // Load the gain-compensated unit vector
         running_in = 1'b1;
         iter_in    = '0;
         x_in       = CORDIC_GAIN_Q30;
         y_in       = '0;
         z_in       = CORDIC_W'(signed'(folded));
      end else if (running_ff) begin
         // Advance one micro-rotation
         if (rotate_pos) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_val;
         end
         iter_in = iter_ff + 1'b1;
         if (last_iter) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done = done_ff;
   assign sine = y_ff;

endmodule

// ----- rtl/core/gso_scale.sv -----
// Gain stage: multiply the Q30 sine by the Q15 amplitude, round and saturate.
// The product is registered, then the sample.
// Depends on gso_pkg.
module gso_scale (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [gso_pkg::CORDIC_W-1:0]    sine,
   input  logic [gso_pkg::AMP_W-1:0]              gain,
   output logic                                   done,
   output logic signed [gso_pkg::SAMPLE_BITS-1:0] sample
);
   import gso_pkg::*;

   logic                          prod_valid_ff;
   logic                          done_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [PROD_W-1:0]      rounded, shifted;

   // Multiply
   assign prod_in = PROD_W'(sine) * PROD_W'(signed'({1'b0, gain}));

   // Round half up, then clamp to the sample range
   assign rounded = prod_ff + ROUND_HALF;
   assign shifted = rounded >>> OUT_SHIFT;

   always_comb begin
      priority if (shifted > SAT_HI) begin
         sample_in = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         sample_in = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sample_in = shifted[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         prod_valid_ff <= start;
         done_ff       <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      sample_ff <= sample_in;
   end

   assign done   = done_ff;
   assign sample = sample_ff;

endmodule
